FILE: hdl/gic_pkg.sv
// shared types, constants and helpers for the gittins index calibration block
`timescale 1ns / 1ps
`default_nettype none
package gic_pkg;
   localparam int MAX_HORIZON = 64;
   localparam int PROB_BITS   = 16;
   localparam int HB          = $clog2(MAX_HORIZON);
   localparam int CNT_W       = HB + 1;
   localparam int ADDR_W      = 2 * HB;
   localparam int VAL_W       = 32;
   localparam int NUM_W       = VAL_W + HB + 2;
   localparam int DVS_W       = PROB_BITS + 1;
   localparam int IDX_W       = PROB_BITS + 1;
   localparam int HZ_W        = 7;
   localparam int COUNT_W     = 11;
   localparam int FIELD_AB_W  = 6;

   localparam logic [HZ_W-1:0]      HORIZON_RESET  = 7'd64;
   localparam logic [PROB_BITS-1:0] DISCOUNT_RESET = 16'd58982;
   localparam logic [PROB_BITS-1:0] STEP_RESET     = 16'd655;
   localparam logic [DVS_W-1:0]     ONE            = DVS_W'(1) << PROB_BITS;
   localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SWEEP = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_HORIZON  = 2'd0,
      CSR_DISCOUNT = 2'd1,
      CSR_STEP     = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DIAG_GO, ST_DIAG_WAIT, ST_SAFE_GO, ST_SAFE_WAIT,
      ST_CELL_RD, ST_CELL_MUL1, ST_CELL_MUL2, ST_DIV_GO, ST_DIV_WAIT, ST_CELL_WR, ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
      logic [CNT_W-1:0] am;
      logic [CNT_W-1:0] bm;
      am = a - CNT_W'(1);
      bm = b - CNT_W'(1);
      return {am[HB-1:0], bm[HB-1:0]};
   endfunction
endpackage
`default_nettype wire

FILE: hdl/gic_ram.sv
// generic synchronous ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module gic_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [(1 << ADDR_W)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

FILE: hdl/gic_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module gic_divider
   import gic_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);
   localparam int DC_W = $clog2(NUM_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DC_W-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = DC_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - DC_W'(1);
         if (cnt_ff == DC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> div_req.divisor != '0) else $error("divide by zero");
`endif
endmodule
`default_nettype wire

FILE: hdl/gittins_index_calibration.sv
// top level: gittins index calibration sequencer with index and value tables
// Usage. Items arrive on the req_ channel (valid/ready); each gives exactly one
// result on the rsp_ channel (valid/ready). Registers are to be written on the
// csr_ port only while the block is idle; the block does not enforce this.
// A clear sweeps the 4096-entry index table, one entry a cycle. A sweep of
// horizon n runs one divider pass per diagonal cell and one for the safe
// value, then a table read, the discounted neighbour products and the
// numerator, one divider pass and a write per triangle cell ((n-1)(n-2)/2
// cells). All divisions share one bit-serial divider.
// One item is in work at a time; req_ready is high while the sequencer idles.
// A finished result sits in the output register; the next item is taken while
// it waits, and that item stalls at its end until the register is free.
// After reset the index table is cleared by a pass over all 4096 entries during
// which no item is taken; registers return to horizon 64, discount 58982, step 655.
`timescale 1ns / 1ps
`default_nettype none
module gittins_index_calibration
   import gic_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_operation,
   input  wire logic [PROB_BITS-1:0]  req_calib_p,
   input  wire logic [FIELD_AB_W-1:0] req_successes,
   input  wire logic [FIELD_AB_W-1:0] req_failures,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [PROB_BITS-1:0]       rsp_index_value,
   output logic                       rsp_index_set,
   output logic [COUNT_W-1:0]         rsp_newly_set,
   output logic                       rsp_saturated,
   input  wire logic                  csr_write_enable,
   input  wire logic [1:0]            csr_index,
   input  wire logic [PROB_BITS-1:0]  csr_write_data
);
   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [PROB_BITS-1:0]  p_ff;
   logic [ADDR_W-1:0]     rd_addr_ff;
   logic                  rd_ok_ff;
   logic [CNT_W-1:0]      a_ff, a_in, nn_ff, nn_in, n_eff, b_cur;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  from_reset_ff, from_reset_in;
   logic [VAL_W-1:0]      safe_ff, safe_in, bv1_ff, bv1_in, bv0_ff, bv0_in, risky;
   logic [PROB_BITS-1:0]  rec_ff, rec_in, half;
   logic                  sat_ff, sat_in, risky_sat;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [HZ_W-1:0]       horizon_ff;
   logic [PROB_BITS-1:0]  discount_ff, step_ff;
   logic                  rsp_load;
   logic [VAL_W+PROB_BITS-1:0] prod1, prod0;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  val_we, val_re, idx_we, idx_re;
   logic [ADDR_W-1:0]     val_waddr, val_raddr1, val_raddr0, idx_waddr, idx_raddr;
   logic [VAL_W-1:0]      val_wdata, val_rdata1, val_rdata0;
   logic [IDX_W-1:0]      idx_wdata, idx_rdata;

   gic_ram #(.WIDTH(VAL_W), .ADDR_W(ADDR_W)) u_val_up (
      .clock, .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
      .re(val_re), .raddr(val_raddr1), .rdata(val_rdata1));
   gic_ram #(.WIDTH(VAL_W), .ADDR_W(ADDR_W)) u_val_right (
      .clock, .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
      .re(val_re), .raddr(val_raddr0), .rdata(val_rdata0));
   gic_ram #(.WIDTH(IDX_W), .ADDR_W(ADDR_W)) u_idx (
      .clock, .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
      .re(idx_re), .raddr(idx_raddr), .rdata(idx_rdata));

   gic_divider u_div (.clock, .reset, .div_req, .div_rsp);

   always_comb begin
      n_eff = (CNT_W'(horizon_ff) > CNT_W'(MAX_HORIZON)) ? CNT_W'(MAX_HORIZON)
                                                         : CNT_W'(horizon_ff);
      b_cur     = nn_ff - a_ff;
      half      = step_ff >> 1;
      prod1     = (VAL_W+PROB_BITS)'(discount_ff) * (VAL_W+PROB_BITS)'(val_rdata1);
      prod0     = (VAL_W+PROB_BITS)'(discount_ff) * (VAL_W+PROB_BITS)'(val_rdata0);
      risky_sat = |div_rsp.quotient[NUM_W-1:VAL_W];
      risky     = risky_sat ? '1 : div_rsp.quotient[VAL_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      nn_in         = nn_ff;
      clr_addr_in   = clr_addr_ff;
      from_reset_in = from_reset_ff;
      safe_in       = safe_ff;
      rec_in        = rec_ff;
      sat_in        = sat_ff;
      count_in      = count_ff;
      bv1_in        = bv1_ff;
      bv0_in        = bv0_ff;
      num_in        = num_ff;
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      div_req       = '0;
      val_we        = 1'b0;
      val_waddr     = '0;
      val_wdata     = '0;
      val_re        = 1'b0;
      val_raddr1    = '0;
      val_raddr0    = '0;
      idx_we        = 1'b0;
      idx_waddr     = '0;
      idx_wdata     = '0;
      idx_re        = 1'b0;
      idx_raddr     = '0;
      case (state_ff)
         ST_CLEAR: begin
            idx_we      = 1'b1;
            idx_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in      = from_reset_ff ? ST_IDLE : ST_DONE;
               from_reset_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  OP_SWEEP: begin
                     count_in = '0;
                     sat_in   = 1'b0;
                     a_in     = CNT_W'(1);
                     state_in = (n_eff < CNT_W'(3)) ? ST_DONE : ST_DIAG_GO;
                  end
                  OP_READ: state_in = ST_READ;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_READ: begin
            idx_re    = 1'b1;
            idx_raddr = rd_addr_ff;
            state_in  = ST_DONE;
         end
         ST_DIAG_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(a_ff) << PROB_BITS;
            div_req.divisor  = DVS_W'(n_eff);
            state_in         = ST_DIAG_WAIT;
         end
         ST_DIAG_WAIT: begin
            if (div_rsp.done) begin
               val_we    = 1'b1;
               val_waddr = cell_addr(a_ff, n_eff - a_ff);
               val_wdata = div_rsp.quotient[VAL_W-1:0];
               if (a_ff == n_eff - CNT_W'(1)) begin
                  state_in = ST_SAFE_GO;
               end else begin
                  a_in     = a_ff + CNT_W'(1);
                  state_in = ST_DIAG_GO;
               end
            end
         end
         ST_SAFE_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(p_ff) << PROB_BITS;
            div_req.divisor  = ONE - DVS_W'(discount_ff);
            state_in         = ST_SAFE_WAIT;
         end
         ST_SAFE_WAIT: begin
            if (div_rsp.done) begin
               safe_in = risky;
               if (risky_sat) begin
                  sat_in = 1'b1;
               end
               if (p_ff >= half) begin
                  rec_in = p_ff - half;
               end else begin
                  rec_in = '0;
                  sat_in = 1'b1;
               end
               nn_in    = n_eff - CNT_W'(1);
               a_in     = CNT_W'(1);
               state_in = ST_CELL_RD;
            end
         end
         ST_CELL_RD: begin
            val_re     = 1'b1;
            val_raddr1 = cell_addr(a_ff + CNT_W'(1), b_cur);
            val_raddr0 = cell_addr(a_ff, b_cur + CNT_W'(1));
            idx_re     = 1'b1;
            idx_raddr  = cell_addr(a_ff, b_cur);
            state_in   = ST_CELL_MUL1;
         end
         ST_CELL_MUL1: begin
            bv1_in   = prod1[VAL_W+PROB_BITS-1:PROB_BITS];
            bv0_in   = prod0[VAL_W+PROB_BITS-1:PROB_BITS];
            state_in = ST_CELL_MUL2;
         end
         ST_CELL_MUL2: begin
            num_in   = NUM_W'(a_ff) * (NUM_W'(bv1_ff) + NUM_W'(ONE))
                     + NUM_W'(b_cur) * NUM_W'(bv0_ff);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = num_ff;
            div_req.divisor  = DVS_W'(nn_ff);
            state_in         = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_CELL_WR;
            end
         end
         ST_CELL_WR: begin
            if (risky_sat) begin
               sat_in = 1'b1;
            end
            val_we    = 1'b1;
            val_waddr = cell_addr(a_ff, b_cur);
            val_wdata = (safe_ff > risky) ? safe_ff : risky;
            if (!idx_rdata[IDX_W-1] && safe_ff > risky) begin
               idx_we    = 1'b1;
               idx_waddr = cell_addr(a_ff, b_cur);
               idx_wdata = {1'b1, rec_ff};
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            if (a_ff + CNT_W'(1) == nn_ff) begin
               a_in  = CNT_W'(1);
               nn_in = nn_ff - CNT_W'(1);
               state_in = (nn_ff == CNT_W'(2)) ? ST_DONE : ST_CELL_RD;
            end else begin
               a_in     = a_ff + CNT_W'(1);
               state_in = ST_CELL_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         from_reset_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         from_reset_ff <= from_reset_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      nn_ff    <= nn_in;
      safe_ff  <= safe_in;
      rec_ff   <= rec_in;
      sat_ff   <= sat_in;
      count_ff <= count_in;
      bv1_ff   <= bv1_in;
      bv0_ff   <= bv0_in;
      num_ff   <= num_in;
      if (req_valid && req_ready) begin
         op_ff      <= op_type'(req_operation);
         p_ff       <= req_calib_p;
         rd_addr_ff <= cell_addr(CNT_W'(req_successes), CNT_W'(req_failures));
         rd_ok_ff   <= (req_successes != '0) && (req_failures != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff  <= HORIZON_RESET;
         discount_ff <= DISCOUNT_RESET;
         step_ff     <= STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_type'(csr_index))
            CSR_HORIZON:  horizon_ff  <= csr_write_data[HZ_W-1:0];
            CSR_DISCOUNT: discount_ff <= csr_write_data;
            CSR_STEP:     step_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // output register, freed by a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (rsp_load) begin
         rsp_index_value <= (op_ff == OP_READ && rd_ok_ff) ? idx_rdata[PROB_BITS-1:0] : '0;
         rsp_index_set   <= (op_ff == OP_READ && rd_ok_ff) ? idx_rdata[IDX_W-1] : 1'b0;
         rsp_newly_set   <= (op_ff == OP_SWEEP) ? count_ff : '0;
         rsp_saturated   <= (op_ff == OP_SWEEP) ? sat_ff : 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CELL_WR |-> nn_ff >= CNT_W'(2) && a_ff < nn_ff)
      else $error("cell outside triangle");
   a_diag_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIAG_WAIT |-> a_ff >= CNT_W'(1) && a_ff < n_eff)
      else $error("diagonal index out of range");
   a_set_by_sweep: assert property (@(posedge clock) disable iff (reset)
      idx_we && idx_wdata[IDX_W-1] |-> state_ff == ST_CELL_WR)
      else $error("index set outside sweep");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      val_we |-> !div_req.start)
      else $error("value write overlaps divider start");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/tb_gittins_index_calibration.sv
// self-checking testbench for the gittins index calibration block
`timescale 1ns / 1ps
module tb_gittins_index_calibration;
   import gic_pkg::*;

   typedef struct {
      op_type                op;
      logic [PROB_BITS-1:0]  p;
      logic [FIELD_AB_W-1:0] a;
      logic [FIELD_AB_W-1:0] b;
   } item_type;

   typedef struct {
      logic [PROB_BITS-1:0] index_value;
      logic                 index_set;
      logic [COUNT_W-1:0]   newly_set;
      logic                 saturated;
   } result_type;

   localparam int DEPTH = MAX_HORIZON * MAX_HORIZON;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_NONE;
   logic [PROB_BITS-1:0] req_calib_p = '0;
   logic [FIELD_AB_W-1:0] req_successes = '0;
   logic [FIELD_AB_W-1:0] req_failures = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PROB_BITS-1:0] rsp_index_value;
   logic rsp_index_set;
   logic [COUNT_W-1:0] rsp_newly_set;
   logic rsp_saturated;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_HORIZON;
   logic [PROB_BITS-1:0] csr_write_data = '0;

   gittins_index_calibration DUT (.*);

   item_type   pending_items[$];
   result_type expected_results[$];

   logic [PROB_BITS-1:0] idx_value[DEPTH];
   logic                 idx_flag[DEPTH];
   logic [31:0]          cell_value[DEPTH];
   int unsigned horizon_reg, discount_reg, step_reg;

   int  errors = 0;
   logic transfer_taken = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  recv_hold = 0;
   logic calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int unsigned cell_index(int unsigned a, int unsigned b);
      return ((a - 1) * MAX_HORIZON + (b - 1)) % DEPTH;
   endfunction

   function automatic void run_sweep(input int unsigned p, output int unsigned count,
                                     output logic sat);
      longint unsigned one, d, sv, v1, v0, num, risky, safe;
      int unsigned n, rec, half, b, addr;
      one = 64'd1 << PROB_BITS;
      d = discount_reg;
      n = horizon_reg > MAX_HORIZON ? MAX_HORIZON : horizon_reg;
      count = 0;
      sat = 1'b0;
      if (n < 3) return;
      for (int unsigned a = 1; a < n; a++)
         cell_value[cell_index(a, n - a)] = 32'((longint'(a) << PROB_BITS) / n);
      sv = (longint'(p) << PROB_BITS) / (one - d);
      if (sv > 64'hFFFF_FFFF) begin
         sv = 64'hFFFF_FFFF;
         sat = 1'b1;
      end
      safe = sv;
      half = step_reg >> 1;
      if (p >= half) begin
         rec = p - half;
      end else begin
         rec = 0;
         sat = 1'b1;
      end
      for (int unsigned nn = n - 1; nn >= 2; nn--) begin
         for (int unsigned a = 1; a + 1 <= nn; a++) begin
            b = nn - a;
            v1 = cell_value[cell_index(a + 1, b)];
            v0 = cell_value[cell_index(a, b + 1)];
            num = a * (one + ((d * v1) >> PROB_BITS)) + b * ((d * v0) >> PROB_BITS);
            risky = num / nn;
            if (risky > 64'hFFFF_FFFF) begin
               risky = 64'hFFFF_FFFF;
               sat = 1'b1;
            end
            addr = cell_index(a, b);
            if (!idx_flag[addr] && safe > risky) begin
               idx_flag[addr] = 1'b1;
               idx_value[addr] = rec[15:0];
               if (count < 2047) count++;
            end
            cell_value[addr] = safe > risky ? safe[31:0] : risky[31:0];
         end
      end
   endfunction

   function automatic result_type predict_result(input item_type it);
      result_type r;
      int unsigned count;
      logic sat;
      r = '{default: '0};
      case (it.op)
         OP_CLEAR: begin
            foreach (idx_flag[i]) begin
               idx_flag[i] = 1'b0;
               idx_value[i] = '0;
            end
         end
         OP_SWEEP: begin
            run_sweep(it.p, count, sat);
            r.newly_set = count[COUNT_W-1:0];
            r.saturated = sat;
         end
         OP_READ: begin
            if (it.a != 0 && it.b != 0) begin
               r.index_value = idx_value[cell_index(it.a, it.b)];
               r.index_set = idx_flag[cell_index(it.a, it.b)];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // transfer accounting and result checks
   always @(posedge clock) begin
      result_type want;
      item_type it;
      transfer_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         it.op = op_type'(req_operation);
         it.p = req_calib_p;
         it.a = req_successes;
         it.b = req_failures;
         expected_results.push_back(predict_result(it));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report("unexpected result", 0, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_index_value !== want.index_value)
               report("index_value", rsp_index_value, want.index_value);
            if (rsp_index_set !== want.index_set)
               report("index_set", rsp_index_set, want.index_set);
            if (rsp_newly_set !== want.newly_set)
               report("newly_set", rsp_newly_set, want.newly_set);
            if (rsp_saturated !== want.saturated)
               report("saturated", rsp_saturated, want.saturated);
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !transfer_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         send_gap <= $urandom_range(1, 12);
         req_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
         it = pending_items.pop_front();
         req_valid <= 1'b1;
         req_operation <= it.op;
         req_calib_p <= it.p;
         req_successes <= it.a;
         req_failures <= it.b;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response ready with bursts of back-pressure
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         recv_gap <= $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic csr_write(input csr_type idx, input int unsigned data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data[15:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_HORIZON:  horizon_reg = data & 32'h7F;
         CSR_DISCOUNT: discount_reg = data & 32'hFFFF;
         default:      step_reg = data & 32'hFFFF;
      endcase
   endtask

   task automatic configure(input int unsigned hz, input int unsigned disc,
                            input int unsigned step);
      csr_write(CSR_HORIZON, hz);
      csr_write(CSR_DISCOUNT, disc);
      csr_write(CSR_STEP, step);
   endtask

   task automatic add_item(input op_type op, input int unsigned p, input int unsigned a,
                           input int unsigned b);
      item_type it;
      it.op = op;
      it.p = p[15:0];
      it.a = a[5:0];
      it.b = b[5:0];
      pending_items.push_back(it);
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add_random(input int unsigned hz);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if ($urandom_range(0, 2) == 0)
            add_item(OP_READ, $urandom, $urandom_range(0, 63), $urandom_range(0, 63));
         else
            add_item(OP_READ, $urandom, $urandom_range(1, hz), $urandom_range(1, hz));
      end else if (pick < 88) begin
         add_item(OP_SWEEP, $urandom_range(0, 65535), $urandom, $urandom);
      end else if (pick < 94) begin
         add_item(OP_CLEAR, $urandom, $urandom, $urandom);
      end else begin
         add_item(OP_NONE, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int unsigned hz;
      foreach (idx_flag[i]) begin
         idx_flag[i] = 1'b0;
         idx_value[i] = '0;
         cell_value[i] = '0;
      end
      horizon_reg = HORIZON_RESET;
      discount_reg = DISCOUNT_RESET;
      step_reg = STEP_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // horizon below the minimum: sweep does nothing
      configure(2, 30000, 1000);
      add_item(OP_READ, 0, 1, 1);
      add_item(OP_SWEEP, 40000, 0, 0);
      add_item(OP_NONE, 16'hFFFF, 63, 63);
      add_item(OP_READ, 0, 0, 5);
      add_item(OP_READ, 0, 5, 0);
      drain();

      // smallest sweeping horizon, zero discount, step of one
      configure(3, 0, 1);
      add_item(OP_SWEEP, 0, 0, 0);
      add_item(OP_SWEEP, 65535, 0, 0);
      add_item(OP_READ, 0, 1, 1);
      add_item(OP_READ, 0, 2, 1);
      add_item(OP_READ, 0, 1, 2);
      add_item(OP_READ, 0, 63, 63);
      drain();

      // horizon above the table, largest discount and step
      configure(127, 65535, 65535);
      add_item(OP_SWEEP, 30000, 0, 0);
      add_item(OP_READ, 0, 1, 1);
      add_item(OP_READ, 0, 32, 31);
      add_item(OP_READ, 0, 63, 63);
      add_item(OP_CLEAR, 0, 0, 0);
      add_item(OP_READ, 0, 1, 1);
      drain();

      configure(0, 58982, 655);
      add_item(OP_SWEEP, 1234, 0, 0);
      drain();

      // long back-pressure while reads keep coming
      configure(8, 58982, 655);
      add_item(OP_SWEEP, 52000, 0, 0);
      drain();
      recv_hold = 400;
      for (int i = 0; i < 10; i++)
         add_item(OP_READ, $urandom, $urandom_range(1, 7), $urandom_range(1, 7));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         hz = $urandom_range(3, 12);
         configure(hz, $urandom_range(0, 65535), $urandom_range(1, 65535));
         if (phase == 3) calm = 1'b1;
         for (int i = 0; i < 30; i++) add_random(hz);
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("gittins_index_calibration regression: pass");
      else
         $display("gittins_index_calibration regression: fail");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("gittins_index_calibration regression: fail");
      $finish;
   end
endmodule
